### src/pfra_pkg.sv
// Shared types and constants for the page frame refcount allocator.
// No dependencies.
`default_nettype none
package pfra_pkg;
	localparam int unsigned LowLimit = 32'h100000;
	localparam logic [7:0] MarkUsed = 8'd100;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_SHARE = 2'd2,
		OP_INIT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_FREE      = 3'd1,
		ST_NONEXIST     = 3'd2,
		ST_ALREADY_FREE = 3'd3,
		ST_LOW          = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_START = 1'b0,
		CFG_END   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [23:0] address;
	} req_t;

	typedef struct packed {
		logic [23:0] page_address;
		logic [2:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CHK, S_SCAN, S_FILL, S_FREE, S_DONE, S_CLR
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request
		logic rd;        // read count at target index
		logic wr;        // write back modified count
		logic scan;      // read next scan entry
		logic fill;      // write one fill entry
		logic fill_init; // start fill sweep
		logic free_init; // start free sweep
		logic done;      // present result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_hit;
		logic scan_end;
		logic fill_end;
		logic free_end;
		logic [1:0] op;
	} sts_t;
endpackage
`default_nettype wire

### src/pfra_ctrl.sv
// Sequencer for the allocator: steps each operation through the datapath.
// Depends on pfra_pkg.
`default_nettype none
module pfra_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire pfra_pkg::sts_t  sts,
	output pfra_pkg::cmd_t       cmd
);
	pfra_pkg::state_t state_q, state_d;

	// reset starts with a sweep that marks every count used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pfra_pkg::S_CLR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != pfra_pkg::S_IDLE);
		case (state_q)
			pfra_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = pfra_pkg::S_RD;
				end
			end
			pfra_pkg::S_RD: begin
				case (sts.op)
					pfra_pkg::OP_ALLOC: begin
						cmd.scan = 1'b1;
						state_d = pfra_pkg::S_SCAN;
					end
					pfra_pkg::OP_INIT: begin
						cmd.fill_init = 1'b1;
						state_d = pfra_pkg::S_FILL;
					end
					default: begin
						cmd.rd = 1'b1;
						state_d = pfra_pkg::S_CHK;
					end
				endcase
			end
			pfra_pkg::S_CHK: begin
				cmd.wr = 1'b1;
				cmd.done = 1'b1;
				state_d = pfra_pkg::S_DONE;
			end
			pfra_pkg::S_SCAN: begin
				if (sts.scan_hit || sts.scan_end) begin
					cmd.wr = 1'b1;
					cmd.done = 1'b1;
					state_d = pfra_pkg::S_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			pfra_pkg::S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_end) begin
					cmd.free_init = 1'b1;
					state_d = pfra_pkg::S_FREE;
				end
			end
			pfra_pkg::S_FREE: begin
				cmd.fill = 1'b1;
				if (sts.free_end) begin
					cmd.done = 1'b1;
					state_d = pfra_pkg::S_DONE;
				end
			end
			pfra_pkg::S_CLR: begin
				cmd.fill = 1'b1;
				if (sts.fill_end) state_d = pfra_pkg::S_IDLE;
			end
			pfra_pkg::S_DONE: state_d = pfra_pkg::S_IDLE;
			default: state_d = pfra_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### src/pfra_datapath.sv
// Count memory, scan/fill counters and result register for the allocator.
// Depends on pfra_pkg.
`default_nettype none
module pfra_datapath #(
	parameter int PAGE_COUNT = 3840
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pfra_pkg::req_t  req,
	input  wire logic [24:0]     free_start,
	input  wire logic [24:0]     free_end,
	input  wire pfra_pkg::cmd_t  cmd,
	output pfra_pkg::sts_t       sts,
	output logic                 result_valid,
	output pfra_pkg::rsp_t       result
);
	localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] Last = CW'(PAGE_COUNT - 1);

	logic [7:0] mem [PAGE_COUNT];
	logic [7:0] rdata_q;
	logic [1:0] op_q;
	logic [23:0] addr_q;
	logic [CW-1:0] ptr_q;     // scan/fill pointer
	logic [CW-1:0] hit_q;     // index of last scan read
	logic          scan_vld_q;
	logic [13:0]   free_left_q;
	logic          fill_zero_q;

	// target index from the address
	logic [11:0] tidx;
	logic        low, beyond, past_end;
	assign tidx = 12'((addr_q - 24'(pfra_pkg::LowLimit)) >> 12);
	assign low = addr_q < 24'(pfra_pkg::LowLimit);
	assign beyond = {1'b0, tidx} >= 13'(PAGE_COUNT);
	assign past_end = {1'b0, addr_q} >= free_end;

	// first index freed at init, may be negative (14 bit signed)
	logic signed [13:0] first;
	logic [24:0] span;
	always_comb begin
		if (free_start >= 25'(pfra_pkg::LowLimit))
			first = 14'($signed({1'b0, 13'((free_start - 25'(pfra_pkg::LowLimit)) >> 12)}));
		else
			first = -14'($signed({1'b0,
				13'(((25'(pfra_pkg::LowLimit) - free_start) + 25'd4095) >> 12)}));
		span = (free_end > free_start) ? ((free_end - free_start) >> 12) : 25'd0;
	end

	logic signed [14:0] fidx;
	assign fidx = 15'(first) + 15'($signed({1'b0, 13'(14'd0)}))
		+ $signed({1'b0, 14'(span[13:0]) - free_left_q});
	logic fidx_ok;
	assign fidx_ok = (fidx >= 0) && (fidx < 15'(PAGE_COUNT));

	assign sts.op = op_q;
	assign sts.scan_hit = scan_vld_q && (rdata_q == 8'd0);
	assign sts.scan_end = scan_vld_q && (hit_q == '0);
	assign sts.fill_end = ptr_q == Last;
	assign sts.free_end = (free_left_q == '0);

	logic [7:0] newval;
	pfra_pkg::status_t st;
	always_comb begin
		newval = rdata_q;
		st = pfra_pkg::ST_OK;
		case (op_q)
			pfra_pkg::OP_FREE: begin
				if (low) st = pfra_pkg::ST_LOW;
				else if (past_end || beyond) st = pfra_pkg::ST_NONEXIST;
				else if (rdata_q == 8'd0) st = pfra_pkg::ST_ALREADY_FREE;
				else newval = rdata_q - 8'd1;
			end
			pfra_pkg::OP_SHARE: begin
				if (low) st = pfra_pkg::ST_LOW;
				else if (beyond) st = pfra_pkg::ST_NONEXIST;
				else if (rdata_q != 8'hFF) newval = rdata_q + 8'd1;
			end
			pfra_pkg::OP_ALLOC: begin
				newval = 8'd1;
				if (!sts.scan_hit) st = pfra_pkg::ST_NO_FREE;
			end
			default: st = pfra_pkg::ST_OK;
		endcase
	end

	logic wr_ok;
	assign wr_ok = (op_q == pfra_pkg::OP_ALLOC) ? sts.scan_hit
		: (op_q == pfra_pkg::OP_FREE) ? (!low && !past_end && !beyond)
		: (!low && !beyond);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.operation;
			addr_q <= req.address;
		end
		if (cmd.rd) rdata_q <= mem[tidx[IW-1:0]];
		if (cmd.scan) begin
			rdata_q <= mem[ptr_q[IW-1:0]];
			hit_q <= ptr_q;
		end
		if (cmd.wr && wr_ok) begin
			if (op_q == pfra_pkg::OP_ALLOC) mem[hit_q[IW-1:0]] <= newval;
			else mem[tidx[IW-1:0]] <= newval;
		end
		if (cmd.fill) begin
			if (fill_zero_q) begin
				if (fidx_ok && free_left_q != '0)
					mem[fidx[IW-1:0]] <= 8'd0;
			end else begin
				mem[ptr_q[IW-1:0]] <= pfra_pkg::MarkUsed;
			end
		end
	end

	// pointers and clear sweep after reset happen in controller-driven fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			scan_vld_q <= 1'b0;
			free_left_q <= '0;
			fill_zero_q <= 1'b0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= cmd.done;
			if (cmd.done) begin
				result.status <= 3'(st);
				result.page_address <= (op_q == pfra_pkg::OP_ALLOC && sts.scan_hit)
					? 24'(pfra_pkg::LowLimit + (32'(hit_q) << 12)) : 24'd0;
			end
			if (cmd.load) begin
				ptr_q <= (req.operation == pfra_pkg::OP_ALLOC) ? Last : '0;
				scan_vld_q <= 1'b0;
				fill_zero_q <= 1'b0;
			end else if (cmd.scan) begin
				scan_vld_q <= 1'b1;
				if (ptr_q != '0) ptr_q <= ptr_q - 1'b1;
			end else if (cmd.fill_init) begin
				ptr_q <= '0;
				fill_zero_q <= 1'b0;
			end else if (cmd.free_init) begin
				fill_zero_q <= 1'b1;
				free_left_q <= 14'(span[13:0]);
			end else if (cmd.fill) begin
				if (fill_zero_q) begin
					if (free_left_q != '0) free_left_q <= free_left_q - 1'b1;
				end else ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.done || cmd.wr) scan_vld_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### src/page_frame_refcount_allocator.sv
// Top level of the page frame refcount allocator.
// Depends on pfra_pkg, pfra_ctrl, pfra_datapath.
//
// Usage:
//  - Command channel: drive cmd (operation, address) with start; a transfer
//    happens at an edge where start is high and busy is low.
//  - Each command yields one result on rsp, flagged by done for one cycle.
//    The receiver cannot stall; the result must be taken that cycle.
//  - Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; ready is
//    always high. Index 0 = free start address, 1 = free end address.
//  - Steps: free/share read the count at the target index, then write
//    it back and flag the result; alloc reads entries from the top down
//    (1..PAGE_COUNT, one memory read per cycle) until a free one or the
//    bottom; init writes every count to used, then clears span entries,
//    span = (end - start) / 4096 when end > start, else 0, one memory
//    write per cycle. busy drops in the cycle after the result.
//  - Reset: registers go to start 0x400000 and end 0x1000000, and a sweep
//    writes every count to 100 (used); busy stays high until the sweep ends.
//  - One command at a time; busy stays high until its result is shown.
`default_nettype none
module page_frame_refcount_allocator #(
	parameter int PAGE_COUNT = 3840
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire pfra_pkg::req_t  cmd,
	output logic                 done,
	output pfra_pkg::rsp_t       rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [0:0]      cfg_index,
	input  wire logic [24:0]     cfg_data
);
	logic [24:0] start_q, end_q;
	pfra_pkg::cmd_t c;
	pfra_pkg::sts_t s;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 25'h400000;
			end_q <= 25'h1000000;
		end else if (cfg_valid) begin
			if (cfg_index == pfra_pkg::CFG_START) start_q <= cfg_data;
			else end_q <= cfg_data;
		end
	end

	pfra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(s), .cmd(c)
	);

	pfra_datapath #(.PAGE_COUNT(PAGE_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(cmd), .free_start(start_q),
		.free_end(end_q), .cmd(c), .sts(s), .result_valid(done), .result(rsp)
	);
endmodule
`default_nettype wire
